// File: hw/rtl/cldc_pkg.sv
// Shared types and constants for the command line checker core.
// Holds verdict codes, config register indexes, character codes and the
// per-track parser state struct. No dependencies.
package cldc_pkg;

    // verdict codes
    localparam logic [2:0] VERDICT_OK         = 3'd0;
    localparam logic [2:0] VERDICT_SHORT      = 3'd1;
    localparam logic [2:0] VERDICT_NO_SUM     = 3'd2;
    localparam logic [2:0] VERDICT_MISMATCH   = 3'd3;
    localparam logic [2:0] VERDICT_FORCED     = 3'd4;
    localparam logic [2:0] VERDICT_BAD_PREFIX = 3'd5;

    // config register indexes
    localparam logic [2:0] CFG_CHECK_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_DECRYPT_ENABLE = 3'd1;
    localparam logic [2:0] CFG_CIPHER_ACTIVE  = 3'd2;
    localparam logic [2:0] CFG_CIPHER_KEY     = 3'd3;
    localparam logic [2:0] CFG_FAULT_INJECT   = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int KEY_W       = 7;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 56;
    localparam int HEAD_BYTES  = 5;

    // character codes
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_X_LOWER = 8'h78;
    localparam logic [7:0] CH_X_UPPER = 8'h58;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TILDE   = 8'd126;
    localparam logic [8:0] WRAP_LIMIT = 9'd32;
    localparam logic [8:0] WRAP_ADD   = 9'd95;
    localparam logic [31:0] AT_V_WORD = 32'h562B5441;

    localparam logic [2:0] HEX_MAX_CHARS = 3'd4;
    localparam logic [3:0] FAULT_LAST    = 4'd9;

    // parser state of one track (raw or decrypted)
    typedef struct packed {
        logic [7:0]  sum;
        logic [7:0]  sum_at_comma;
        logic        comma_valid;
        logic [15:0] hex_value;
        logic [2:0]  hex_chars;
        logic        hex_done;
    } t_track;

endpackage

// File: hw/rtl/command_line_decrypt_and_checksum_core.sv
// Top level of the command line checker: decryption, checksum parsing and
// verdict generation in one registered pass per byte.
// Depends on cldc_pkg.

// Takes one byte of a command line per clock on the slave stream (tlast marks
// the final byte) and gives one verdict word on the master stream for every
// line, registered when its final byte is taken. Every byte updates a raw and a
// decrypted parser track in the same cycle, so the core sustains one byte per
// clock; a verdict sits in a single output register, and only a final byte
// that would overwrite an untaken verdict is held off. Config writes are
// always ready and should be made between lines.
module command_line_decrypt_and_checksum_core
    import cldc_pkg::*;
#(
    parameter int MAX_LINE = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // line bytes
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,  // [7:0] line_byte
    input  logic                   i_s_axis_tlast,  // line_end
    // verdicts
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [2:0] verdict, [10:3] command_letter, [18:11] sub_letter,
    // [27:19] body_length, [43:28] received_sum, [51:44] computed_sum, [55:52] zero
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    localparam int CW = $clog2(MAX_LINE + 1);

    // config registers
    logic             r_check_en;
    logic             r_decrypt_en;
    logic             r_cipher_active;
    logic [KEY_W-1:0] r_key;
    logic             r_fault_inject;

    // line state
    logic [CW-1:0]         r_byte_count, n_byte_count;
    logic [8*HEAD_BYTES-1:0] r_head_raw, n_head_raw;
    logic [8*HEAD_BYTES-1:0] r_head_plain, n_head_plain;
    t_track                r_trk [2];
    t_track                n_trk [2];
    logic [CW-1:0]         r_comma_pos [2];
    logic [CW-1:0]         n_comma_pos [2];
    logic [3:0]            r_fault_cnt, n_fault_cnt;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic          take, line_done, cnt_ok;
    logic [7:0]    in_byte, plain_byte;
    logic          apply, sel, comma_ok;
    t_track        fin;
    logic [CW-1:0] fin_len;
    logic [8*HEAD_BYTES-1:0] fin_head;
    logic [2:0]    verdict;
    logic [15:0]   recv;
    logic [7:0]    comp;
    logic [7:0]    cmd_letter, sub_letter;
    logic [8:0]    body_len;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        // bit 4 flags a valid digit
        logic [4:0] d;
        d = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

    function automatic t_track track_next(input t_track s, input logic [7:0] c);
        t_track     t;
        logic [4:0] d;
        t = s;
        d = hex_digit(c);
        if (c == CH_COMMA) begin
            t.comma_valid  = 1'b1;
            t.sum_at_comma = s.sum;
            t.hex_value    = 16'd0;
            t.hex_chars    = 3'd0;
            t.hex_done     = 1'b0;
        end else if (s.comma_valid && !s.hex_done && s.hex_chars < HEX_MAX_CHARS) begin
            if (d[4]) begin
                t.hex_value = {s.hex_value[11:0], d[3:0]};
                t.hex_chars = s.hex_chars + 3'd1;
            end else if ((c == CH_X_LOWER || c == CH_X_UPPER) && s.hex_chars == 3'd1
                         && s.hex_value == 16'd0) begin
                t.hex_chars = s.hex_chars + 3'd1;
            end else begin
                t.hex_done = 1'b1;
            end
        end
        t.sum = s.sum + c;
        return t;
    endfunction

    function automatic logic [7:0] decrypt(input logic [7:0] c, input logic [KEY_W-1:0] key);
        logic [8:0] diff;
        logic [7:0] res;
        diff = {1'b0, c} - {2'b00, key};
        res  = c;
        if (c >= CH_SPACE && c <= CH_TILDE) begin
            // wrap back into the printable range
            if ($signed(diff) < $signed(WRAP_LIMIT)) begin
                res = 8'(diff + WRAP_ADD);
            end else begin
                res = diff[7:0];
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] head_byte(input logic [8*HEAD_BYTES-1:0] h,
                                             input int k, input logic [CW-1:0] len);
        logic [7:0] b;
        b = 8'd0;
        if (CW'(k) < len) begin
            b = h[8*k +: 8];
        end
        return b;
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready || !i_s_axis_tlast;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign take      = i_s_axis_tvalid && o_s_axis_tready;
    assign line_done = take && i_s_axis_tlast;
    assign in_byte   = i_s_axis_tdata;
    assign cnt_ok    = r_byte_count < CW'(MAX_LINE);
    assign plain_byte = decrypt(in_byte, r_key);

    // per-byte update of both tracks
    always_comb begin
        n_byte_count = r_byte_count;
        n_head_raw   = r_head_raw;
        n_head_plain = r_head_plain;
        for (int t = 0; t < 2; t++) begin
            n_trk[t]       = r_trk[t];
            n_comma_pos[t] = r_comma_pos[t];
        end
        if (cnt_ok) begin
            n_byte_count = r_byte_count + CW'(1);
            for (int k = 0; k < HEAD_BYTES; k++) begin
                if (r_byte_count == CW'(k)) begin
                    n_head_raw[8*k +: 8]   = in_byte;
                    n_head_plain[8*k +: 8] = plain_byte;
                end
            end
            n_trk[0] = track_next(r_trk[0], in_byte);
            n_trk[1] = track_next(r_trk[1], plain_byte);
            if (in_byte == CH_COMMA) begin
                n_comma_pos[0] = r_byte_count;
            end
            if (plain_byte == CH_COMMA) begin
                n_comma_pos[1] = r_byte_count;
            end
        end
    end

    // verdict from the state including the final byte
    always_comb begin
        apply    = r_decrypt_en && r_cipher_active && (n_head_raw[31:0] != AT_V_WORD);
        sel      = apply;
        fin      = sel ? n_trk[1] : n_trk[0];
        fin_head = sel ? n_head_plain : n_head_raw;
        comma_ok = fin.comma_valid && ((sel ? n_comma_pos[1] : n_comma_pos[0]) != '0);
        fin_len  = n_byte_count;
        verdict  = VERDICT_OK;
        recv     = 16'd0;
        comp     = 8'd0;
        n_fault_cnt = r_fault_cnt;
        if (n_byte_count < CW'(4)) begin
            verdict  = VERDICT_SHORT;
            fin_head = n_head_raw;
        end else begin
            if (!comma_ok) begin
                if (r_check_en) begin
                    verdict = VERDICT_NO_SUM;
                end
            end else begin
                fin_len = sel ? n_comma_pos[1] : n_comma_pos[0];
                recv    = fin.hex_value;
                comp    = fin.sum_at_comma;
                n_fault_cnt = (r_fault_cnt == FAULT_LAST) ? 4'd0 : r_fault_cnt + 4'd1;
                if (r_fault_inject && n_fault_cnt == 4'd0) begin
                    verdict = VERDICT_FORCED;
                end else if (r_check_en && recv != {8'd0, comp}) begin
                    verdict = VERDICT_MISMATCH;
                end
            end
            if (verdict == VERDICT_OK &&
                (head_byte(fin_head, 0, fin_len) != CH_A ||
                 head_byte(fin_head, 1, fin_len) != CH_T ||
                 head_byte(fin_head, 2, fin_len) != CH_PLUS)) begin
                verdict = VERDICT_BAD_PREFIX;
            end
        end
        cmd_letter = head_byte(fin_head, 3, fin_len);
        sub_letter = head_byte(fin_head, 4, fin_len);
        body_len   = (32'(fin_len) > 32'd511) ? 9'd511 : 9'(fin_len);
        n_out_data = {4'd0, comp, recv, body_len, sub_letter, cmd_letter, verdict};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_en      <= 1'b1;
            r_decrypt_en    <= 1'b0;
            r_cipher_active <= 1'b0;
            r_key           <= KEY_W'(1);
            r_fault_inject  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHECK_ENABLE:   r_check_en      <= i_cfg_data[0];
                CFG_DECRYPT_ENABLE: r_decrypt_en    <= i_cfg_data[0];
                CFG_CIPHER_ACTIVE:  r_cipher_active <= i_cfg_data[0];
                CFG_CIPHER_KEY:     r_key           <= i_cfg_data[KEY_W-1:0];
                CFG_FAULT_INJECT:   r_fault_inject  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || line_done) begin
            r_byte_count <= '0;
            r_head_raw   <= '0;
            r_head_plain <= '0;
            for (int t = 0; t < 2; t++) begin
                r_trk[t]       <= '0;
                r_comma_pos[t] <= '0;
            end
        end else if (take) begin
            r_byte_count <= n_byte_count;
            r_head_raw   <= n_head_raw;
            r_head_plain <= n_head_plain;
            for (int t = 0; t < 2; t++) begin
                r_trk[t]       <= n_trk[t];
                r_comma_pos[t] <= n_comma_pos[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_cnt <= 4'd0;
            r_out_valid <= 1'b0;
        end else if (line_done) begin
            r_fault_cnt <= n_fault_cnt;
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_done) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: bench/command_line_decrypt_and_checksum_core_test.sv
// Self-checking bench for the command line checker core: random and directed
// command lines go in as byte words, verdict words are checked against an inline
// predictor of the decrypt, checksum and prefix logic. Depends on cldc_pkg.
module command_line_decrypt_and_checksum_core_test
    import cldc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT  = 512;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_line_byte;

    // same layout as o_m_axis_tdata[51:0], lowest field last
    typedef struct packed {
        logic [7:0]  computed_sum;
        logic [15:0] received_sum;
        logic [8:0]  body_length;
        logic [7:0]  sub_letter;
        logic [7:0]  command_letter;
        logic [2:0]  verdict;
    } t_verdict_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tlast = 1'b0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;

    command_line_decrypt_and_checksum_core #(
        .MAX_LINE(LINE_LIMIT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),   // [7:0] line_byte
        .i_s_axis_tlast (i_s_axis_tlast),   // line_end
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        // [2:0] verdict, [10:3] command_letter, [18:11] sub_letter,
        // [27:19] body_length, [43:28] received_sum, [51:44] computed_sum
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus side
    t_line_byte    line_q[$];
    logic [7:0]    line_buf[$];
    int            bytes_queued = 0;
    bit            gen_encrypt = 1'b0;
    logic [6:0]    gen_key = 7'd1;
    bit            steady = 1'b0;
    bit            hold_req = 1'b0;
    bit            byte_taken = 1'b0;

    // predictor copy of registers and line state
    bit            cfg_check = 1'b1;
    bit            cfg_decrypt = 1'b0;
    bit            cfg_active = 1'b0;
    logic [6:0]    cfg_key = 7'd1;
    bit            cfg_fault = 1'b0;
    int            line_len = 0;
    logic [39:0]   head_raw = '0;
    logic [39:0]   head_plain = '0;
    logic [7:0]    track_sum[2];
    logic [7:0]    sum_at_comma[2];
    bit            comma_seen[2];
    int            comma_at[2];
    logic [15:0]   hex_val[2];
    int            hex_cnt[2];
    bit            hex_stop[2];
    int            fault_step = 0;
    t_verdict_word verdict_q[$];

    int            errors = 0;
    int            verdicts_seen = 0;
    int            quiet_cycles = 0;

    function automatic logic [7:0] shift_back(logic [7:0] c, logic [6:0] key);
        int code;
        if (c < CH_SPACE || c > CH_TILDE) return c;
        code = int'(c) - int'(key);
        if (code < int'(WRAP_LIMIT)) code += int'(WRAP_ADD);
        return code[7:0];
    endfunction

    function automatic logic [7:0] shift_fwd(logic [7:0] c, logic [6:0] key);
        int code;
        if (c < CH_SPACE || c > CH_TILDE) return c;
        code = int'(c) + int'(key);
        if (code > int'(CH_TILDE)) code -= int'(WRAP_ADD);
        return code[7:0];
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] head_at(logic [39:0] head, int k, int len);
        if (k >= len || k > 4) return 8'h00;
        return head[8*k +: 8];
    endfunction

    function automatic void clear_line();
        line_len = 0;
        head_raw = '0;
        head_plain = '0;
        for (int t = 0; t < 2; t++) begin
            track_sum[t] = '0;
            sum_at_comma[t] = '0;
            comma_seen[t] = 1'b0;
            comma_at[t] = 0;
            hex_val[t] = '0;
            hex_cnt[t] = 0;
            hex_stop[t] = 1'b0;
        end
    endfunction

    // checksum field parser of one track, raw (0) or decrypted (1)
    function automatic void scan_char(int t, logic [7:0] c, int pos);
        int d;
        if (c == CH_COMMA) begin
            comma_seen[t] = 1'b1;
            comma_at[t] = pos;
            sum_at_comma[t] = track_sum[t];
            hex_val[t] = '0;
            hex_cnt[t] = 0;
            hex_stop[t] = 1'b0;
        end else if (comma_seen[t] && !hex_stop[t] && hex_cnt[t] < int'(HEX_MAX_CHARS)) begin
            d = hex_nibble(c);
            if (d >= 0) begin
                hex_val[t] = {hex_val[t][11:0], d[3:0]};
                hex_cnt[t]++;
            end else if ((c == CH_X_LOWER || c == CH_X_UPPER) && hex_cnt[t] == 1
                         && hex_val[t] == 0) begin
                hex_cnt[t]++;
            end else begin
                hex_stop[t] = 1'b1;
            end
        end
        track_sum[t] = track_sum[t] + c;
    endfunction

    function automatic void absorb_byte(logic [7:0] c, logic last);
        logic [7:0]    d;
        logic [39:0]   head;
        t_verdict_word v;
        int            len;
        int            t;
        bit            apply;
        if (line_len < LINE_LIMIT) begin
            d = shift_back(c, cfg_key);
            if (line_len < HEAD_BYTES) begin
                head_raw[8*line_len +: 8] = c;
                head_plain[8*line_len +: 8] = d;
            end
            scan_char(0, c, line_len);
            scan_char(1, d, line_len);
            line_len++;
        end
        if (!last) return;

        v = '0;
        len = line_len;
        head = head_raw;
        if (len < 4) begin
            v.verdict = VERDICT_SHORT;
        end else begin
            // a raw line starting AT+V is never decrypted
            apply = cfg_decrypt && cfg_active && head_raw[31:0] != AT_V_WORD;
            t = apply ? 1 : 0;
            if (apply) head = head_plain;
            if (!comma_seen[t] || comma_at[t] < 1) begin
                if (cfg_check) v.verdict = VERDICT_NO_SUM;
            end else begin
                len = comma_at[t];
                v.received_sum = hex_val[t];
                v.computed_sum = sum_at_comma[t];
                fault_step = (fault_step + 1) % 10;
                if (cfg_fault && fault_step == 0) begin
                    v.verdict = VERDICT_FORCED;
                end else if (cfg_check && hex_val[t] != {8'h00, sum_at_comma[t]}) begin
                    v.verdict = VERDICT_MISMATCH;
                end
            end
            if (v.verdict == VERDICT_OK && (head_at(head, 0, len) != CH_A ||
                head_at(head, 1, len) != CH_T || head_at(head, 2, len) != CH_PLUS))
                v.verdict = VERDICT_BAD_PREFIX;
        end
        v.command_letter = head_at(head, 3, len);
        v.sub_letter = head_at(head, 4, len);
        v.body_length = len > 511 ? 9'd511 : 9'(len);
        verdict_q.push_back(v);
        clear_line();
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("verdict %0d %s: got 0x%0h, want 0x%0h", verdicts_seen, field, got, want);
    endtask

    // monitor: verdict check first, then predictor update for the new byte
    always @(posedge i_clk) begin
        t_verdict_word got;
        t_verdict_word want;
        byte_taken = i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_verdict_word'(o_m_axis_tdata[51:0]);
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected word", int'(got.verdict), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.verdict != want.verdict)
                        report_mismatch("verdict", int'(got.verdict), int'(want.verdict));
                    if (got.command_letter != want.command_letter)
                        report_mismatch("command_letter", int'(got.command_letter),
                                        int'(want.command_letter));
                    if (got.sub_letter != want.sub_letter)
                        report_mismatch("sub_letter", int'(got.sub_letter),
                                        int'(want.sub_letter));
                    if (got.body_length != want.body_length)
                        report_mismatch("body_length", int'(got.body_length),
                                        int'(want.body_length));
                    if (got.received_sum != want.received_sum)
                        report_mismatch("received_sum", int'(got.received_sum),
                                        int'(want.received_sum));
                    if (got.computed_sum != want.computed_sum)
                        report_mismatch("computed_sum", int'(got.computed_sum),
                                        int'(want.computed_sum));
                end
                verdicts_seen++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHECK_ENABLE:   cfg_check = i_cfg_data[0];
                    CFG_DECRYPT_ENABLE: cfg_decrypt = i_cfg_data[0];
                    CFG_CIPHER_ACTIVE:  cfg_active = i_cfg_data[0];
                    CFG_CIPHER_KEY:     cfg_key = i_cfg_data[KEY_W-1:0];
                    CFG_FAULT_INJECT:   cfg_fault = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (byte_taken) absorb_byte(i_s_axis_tdata, i_s_axis_tlast);
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        t_line_byte w;
        if (!i_s_axis_tvalid || byte_taken) begin
            if (i_rst_n && line_q.size() > 0 && (steady || $urandom_range(99) >= 26)) begin
                w = line_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= w.data;
                i_s_axis_tlast <= w.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // verdict receiver, with one long hold-off on request
    int hold_left = 0;
    bit hold_started = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= steady || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic void flush_line(bit plain);
        t_line_byte w;
        for (int i = 0; i < line_buf.size(); i++) begin
            w.data = (gen_encrypt && !plain) ? shift_fwd(line_buf[i], gen_key) : line_buf[i];
            w.last = (i == line_buf.size() - 1);
            line_q.push_back(w);
        end
        bytes_queued += line_buf.size();
    endfunction

    function automatic void queue_text(string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
        flush_line(1'b1);
    endfunction

    // prefix_mode: 0 plain command, 1 AT+V (sent unencrypted), 2 damaged prefix
    function automatic void queue_command(int prefix_mode, int fmt, bit bad);
        logic [7:0] sum;
        string      hex_txt;
        int         n;
        int         f;
        line_buf.delete();
        line_buf.push_back(CH_A);
        line_buf.push_back(CH_T);
        line_buf.push_back(CH_PLUS);
        line_buf.push_back(prefix_mode == 1 ? AT_V_WORD[31:24] : rand_letter());
        line_buf.push_back(rand_letter());
        n = $urandom_range(0, 6);
        repeat (n) line_buf.push_back(rand_printable());
        if (prefix_mode == 2) line_buf[$urandom_range(0, 2)] = rand_printable();
        sum = '0;
        foreach (line_buf[i]) sum = sum + line_buf[i];
        if (bad) sum = sum + 8'($urandom_range(1, 255));
        line_buf.push_back(CH_COMMA);
        f = fmt < 0 ? $urandom_range(0, 9) : fmt;
        case (f)
            0: hex_txt = $sformatf("%02X", sum);
            1: hex_txt = $sformatf("%02x", sum);
            2: hex_txt = $sformatf("0x%02X", sum);
            3: hex_txt = $sformatf("0X%02x", sum);
            4: hex_txt = $sformatf("%04X", sum);
            5: hex_txt = $sformatf("%0X", sum);
            6: hex_txt = $sformatf("%02Xg;", sum);   // parse stops on junk
            7: hex_txt = $sformatf("%06X", sum);     // too many digits
            8: hex_txt = "";
            default: hex_txt = "0x";
        endcase
        for (int i = 0; i < hex_txt.len(); i++) line_buf.push_back(hex_txt[i]);
        flush_line(prefix_mode == 1 || $urandom_range(19) == 0);
    endfunction

    function automatic void queue_long_line(int fill, bit with_sum);
        logic [7:0] sum;
        string      hex_txt;
        line_buf.delete();
        line_buf.push_back(CH_A);
        line_buf.push_back(CH_T);
        line_buf.push_back(CH_PLUS);
        repeat (fill) line_buf.push_back(rand_letter());
        if (with_sum) begin
            sum = '0;
            foreach (line_buf[i]) sum = sum + line_buf[i];
            line_buf.push_back(CH_COMMA);
            hex_txt = $sformatf("%02X", sum);
            for (int i = 0; i < hex_txt.len(); i++) line_buf.push_back(hex_txt[i]);
        end
        flush_line(1'b1);
    endfunction

    function automatic void queue_random_line();
        int r;
        int pm;
        int n;
        r = $urandom_range(99);
        if (r < 70) begin
            pm = $urandom_range(99);
            queue_command(pm < 8 ? 1 : (pm < 13 ? 2 : 0), -1, $urandom_range(99) < 12);
        end else if (r < 94) begin
            line_buf.delete();
            if (r < 80) begin
                n = $urandom_range(1, 12);
                repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 86) begin
                n = $urandom_range(1, 3);
                repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                // no comma at all
                line_buf.push_back(CH_A);
                line_buf.push_back(CH_T);
                line_buf.push_back(CH_PLUS);
                n = $urandom_range(1, 8);
                repeat (n) line_buf.push_back(rand_letter());
            end else begin
                // only comma is the first byte
                line_buf.push_back(CH_COMMA);
                n = $urandom_range(3, 8);
                repeat (n) line_buf.push_back(rand_letter());
            end
            flush_line(1'($urandom_range(1)));
        end else begin
            queue_command(0, $urandom_range(6, 9), 1'b0);
        end
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(bit check, bit dec, bit act, logic [6:0] key, bit fault);
        write_reg(CFG_CHECK_ENABLE, CFG_DATA_W'(check));
        write_reg(CFG_DECRYPT_ENABLE, CFG_DATA_W'(dec));
        write_reg(CFG_CIPHER_ACTIVE, CFG_DATA_W'(act));
        write_reg(CFG_CIPHER_KEY, key);
        write_reg(CFG_FAULT_INJECT, CFG_DATA_W'(fault));
        gen_encrypt = dec && act;
        gen_key = key;
    endtask

    task automatic wait_drained();
        while (line_q.size() != 0 || i_s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        // verdict register is loaded when the final byte is taken
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_lines(int count);
        int goal;
        goal = bytes_queued + count;
        while (bytes_queued < goal) queue_random_line();
        wait_drained();
    endtask

    initial begin
        clear_line();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: checksum required, no decryption
        queue_text("AT");
        queue_text(",1F0");
        queue_text("AT+QX");
        line_buf.delete();
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CH_COMMA);
        line_buf.push_back(8'h80);
        flush_line(1'b1);
        queue_command(2, 2, 1'b0);
        queue_command(0, 1, 1'b1);
        wait_drained();
        run_lines(120);

        set_mode(1'b1, 1'b1, 1'b1, 7'd1, 1'b1);
        steady = 1'b1;
        run_lines(120);
        steady = 1'b0;

        set_mode(1'b1, 1'b1, 1'b1, 7'd94, 1'b0);
        hold_req = 1'b1;
        run_lines(120);

        set_mode(1'b0, 1'b1, 1'b0, 7'd50, 1'b1);
        run_lines(120);

        // lines past the length limit, checksum off
        set_mode(1'b0, 1'b0, 1'b1, 7'd127, 1'b0);
        queue_long_line(510, 1'b0);
        queue_long_line(513, 1'b1);
        run_lines(120);

        set_mode(1'b1, 1'b1, 1'b1, 7'd0, 1'b1);
        run_lines(120);

        set_mode(1'b1, 1'b1, 1'b1, 7'($urandom_range(95, 127)), 1'b0);
        run_lines(120);

        set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 7'($urandom_range(1, 94)), 1'b1);
        run_lines(120);

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
